// ----- rtl/core/erd_pkg.sv -----
// erd_pkg: shared types and constants for the elevation record deframer
// no dependencies; used by every module in rtl/core
package erd_pkg;

  localparam int unsigned MAX_POSTS = 4095;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned POS_W     = $clog2(8 + 2 * MAX_POSTS + 4);

  localparam logic [7:0]       SENTINEL    = 8'hAA;
  localparam logic [CFG_W-1:0] POSTS_RESET = CFG_W'(1201);

  localparam logic [POS_W-1:0] POS_BLOCK = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LON   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LAT   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_POSTS = POS_W'(8);
  localparam logic [POS_W-1:0] POS_TAIL  = POS_W'(3);

  typedef enum logic [1:0] {
    KIND_POST    = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              result_kind;
    logic signed [15:0] elevation;
    logic [IDX_W-1:0]   post_index;
    logic [15:0]        block_count;
    logic [15:0]        longitude_index;
    logic [15:0]        latitude_index;
    logic [31:0]        stored_sum;
    logic [31:0]        computed_sum;
    logic               sum_matches;
  } result_t;

endpackage

// ----- rtl/core/erd_parse.sv -----
// erd_parse: record parser state and the per-word decode logic
// depends on erd_pkg
module erd_parse (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [7:0]               byte_i,
  input  logic                     start_i,
  input  logic [erd_pkg::CFG_W-1:0] posts_i,
  output logic                     res_valid_o,
  output erd_pkg::result_t         res_o
);

  logic [erd_pkg::POS_W-1:0] pos_q, pos_d;
  logic                      skip_q, skip_d;
  logic [7:0]                hold_q, hold_d;
  logic [15:0]               block_q, block_d;
  logic [15:0]               lon_q, lon_d;
  logic [15:0]               lat_q, lat_d;
  logic [31:0]               sum_q, sum_d;
  logic [31:0]               trail_q, trail_d;
  logic [erd_pkg::IDX_W-1:0] cnt_q, cnt_d;

  logic [erd_pkg::POS_W-1:0] posts;
  logic [erd_pkg::POS_W-1:0] data_end;
  logic [erd_pkg::POS_W-1:0] last_pos;
  logic [15:0]               word;
  logic [15:0]               mag;

  // saturate the post count and place the trailer
  always_comb begin
    if (32'(posts_i) > 32'(erd_pkg::MAX_POSTS)) begin
      posts = erd_pkg::POS_W'(erd_pkg::MAX_POSTS);
    end else begin
      posts = erd_pkg::POS_W'(posts_i);
    end
    data_end = erd_pkg::POS_POSTS + (posts << 1);
    last_pos = data_end + erd_pkg::POS_TAIL;
  end

  assign word = {hold_q, byte_i};
  assign mag  = {1'b0, word[14:0]};

  always_comb begin
    pos_d       = pos_q;
    skip_d      = skip_q;
    hold_d      = hold_q;
    block_d     = block_q;
    lon_d       = lon_q;
    lat_d       = lat_q;
    sum_d       = sum_q;
    trail_d     = trail_q;
    cnt_d       = cnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (start_i) begin
      pos_d   = '0;
      hold_d  = '0;
      block_d = '0;
      lon_d   = '0;
      lat_d   = '0;
      sum_d   = '0;
      trail_d = '0;
      cnt_d   = '0;
      if (byte_i != erd_pkg::SENTINEL) begin
        skip_d            = 1'b1;
        res_valid_o       = 1'b1;
        res_o.result_kind = erd_pkg::KIND_ERROR;
      end else begin
        skip_d = 1'b0;
        sum_d  = 32'(byte_i);
        pos_d  = erd_pkg::POS_W'(1);
      end
    end else if (!skip_q) begin
      if (pos_q < data_end) begin
        sum_d = sum_q + 32'(byte_i);
        pos_d = pos_q + erd_pkg::POS_W'(1);
        if (pos_q == erd_pkg::POS_BLOCK || pos_q == erd_pkg::POS_LON ||
            pos_q == erd_pkg::POS_LAT) begin
          hold_d = byte_i;
        end else if (pos_q == erd_pkg::POS_BLOCK + erd_pkg::POS_W'(1)) begin
          block_d = word;
        end else if (pos_q == erd_pkg::POS_LON + erd_pkg::POS_W'(1)) begin
          lon_d = word;
        end else if (pos_q == erd_pkg::POS_LAT + erd_pkg::POS_W'(1)) begin
          lat_d = word;
        end else if (pos_q >= erd_pkg::POS_POSTS) begin
          if (!pos_q[0]) begin
            hold_d = byte_i;
          end else begin
            res_valid_o       = 1'b1;
            res_o.result_kind = erd_pkg::KIND_POST;
            res_o.elevation   = word[15] ? -mag : mag;
            res_o.post_index  = cnt_q;
            cnt_d             = cnt_q + erd_pkg::IDX_W'(1);
          end
        end
      end else begin
        trail_d = {trail_q[23:0], byte_i};
        if (pos_q >= last_pos) begin
          res_valid_o           = 1'b1;
          res_o.result_kind     = erd_pkg::KIND_SUMMARY;
          res_o.block_count     = block_q;
          res_o.longitude_index = lon_q;
          res_o.latitude_index  = lat_q;
          res_o.stored_sum      = trail_d;
          res_o.computed_sum    = sum_q;
          res_o.sum_matches     = (trail_d == sum_q);
          skip_d                = 1'b1;
          pos_d                 = '0;
        end else begin
          pos_d = pos_q + erd_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      skip_q  <= 1'b1;
      hold_q  <= '0;
      block_q <= '0;
      lon_q   <= '0;
      lat_q   <= '0;
      sum_q   <= '0;
      trail_q <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      skip_q  <= skip_d;
      hold_q  <= hold_d;
      block_q <= block_d;
      lon_q   <= lon_d;
      lat_q   <= lat_d;
      sum_q   <= sum_d;
      trail_q <= trail_d;
      cnt_q   <= cnt_d;
    end
  end

  // summary closes the record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.result_kind == erd_pkg::KIND_SUMMARY |=> skip_q)
    else $error("summary did not close the record");

  // sentinel errors only come from a start word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.result_kind == erd_pkg::KIND_ERROR |-> start_i)
    else $error("error result without record start");

  // posts never follow a closed record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q && !start_i |-> !res_valid_o)
    else $error("result while skipping");

  // position stays inside the record layout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skip_q |-> pos_q != '0)
    else $error("active record at position zero");

endmodule

// ----- rtl/core/erd_out_stage.sv -----
// erd_out_stage: result register that holds a word until the sink takes it
// depends on erd_pkg
module erd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  erd_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             valid_o,
  output erd_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  erd_pkg::result_t res_q;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/core/elevation_record_deframer.sv -----
// elevation_record_deframer: top level with input register, parser and result register
// depends on erd_pkg, erd_parse and erd_out_stage
//
// Takes one record byte per word and returns posts, a record summary or a bad
// sentinel error. Sustained rate is one input word per clock while no result is
// left waiting in the result register. A result becomes valid once its input word has
// passed the input register and the parser's single decode pass has landed in the result register.
// The input side keeps moving while a result waits as long as the result register
// is being emptied.
// posts_per_record is taken on the cfg channel at any time (always ready) and
// should only change while the block is idle.
module elevation_record_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [erd_pkg::CFG_W-1:0] posts_per_record_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      record_start_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                result_kind_o,
  output logic signed [15:0]        elevation_o,
  output logic [erd_pkg::IDX_W-1:0] post_index_o,
  output logic [15:0]               block_count_o,
  output logic [15:0]               longitude_index_o,
  output logic [15:0]               latitude_index_o,
  output logic [31:0]               stored_sum_o,
  output logic [31:0]               computed_sum_o,
  output logic                      sum_matches_o
);

  logic [erd_pkg::CFG_W-1:0] posts_q;
  logic                      in_valid_q, in_valid_d;
  logic [7:0]                byte_q;
  logic                      start_q;
  logic                      step;
  logic                      res_valid;
  erd_pkg::result_t          res;
  erd_pkg::result_t          out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posts_q <= erd_pkg::POSTS_RESET;
    end else if (cfg_valid_i) begin
      posts_q <= posts_per_record_i;
    end
  end

  // input register advances when the result slot can take a word
  assign step       = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_comb begin
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= data_byte_i;
      start_q <= record_start_i;
    end
  end

  erd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .start_i     (start_q),
    .posts_i     (posts_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  erd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign result_kind_o     = out_res.result_kind;
  assign elevation_o       = out_res.elevation;
  assign post_index_o      = out_res.post_index;
  assign block_count_o     = out_res.block_count;
  assign longitude_index_o = out_res.longitude_index;
  assign latitude_index_o  = out_res.latitude_index;
  assign stored_sum_o      = out_res.stored_sum;
  assign computed_sum_o    = out_res.computed_sum;
  assign sum_matches_o     = out_res.sum_matches;

  // match flag only rides on a summary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sum_matches_o |-> result_kind_o == erd_pkg::KIND_SUMMARY)
    else $error("match flag outside summary");

  // a waiting result blocks the parser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !step)
    else $error("parser stepped into a full result slot");

  // held input word is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(byte_q) && $stable(start_q))
    else $error("input register lost a word");

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench for elevation_record_deframer
// depends on erd_pkg and the rtl/core sources; record streams are predicted in a scoreboard class
// directed header, post and checksum cases around random record streams with stalls
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  class deframe_scoreboard;
    logic [erd_pkg::CFG_W-1:0] posts_cfg;
    int unsigned               pos;
    bit                        skipping;
    logic [7:0]                hold;
    logic [15:0]               blk;
    logic [15:0]               lon;
    logic [15:0]               lat;
    logic [31:0]               byte_sum;
    logic [31:0]               trail;
    logic [erd_pkg::IDX_W-1:0] post_cnt;
    erd_pkg::result_t          due_results[$];
    int                        errors;

    function new();
      posts_cfg = erd_pkg::POSTS_RESET;
      clear_record();
      skipping = 1'b1;
      errors = 0;
    endfunction

    function void clear_record();
      pos = 0;
      hold = '0;
      blk = '0;
      lon = '0;
      lat = '0;
      byte_sum = '0;
      trail = '0;
      post_cnt = '0;
    endfunction

    // returns 1 when the word was not ignored
    function bit note_word(logic [7:0] b, logic first);
      erd_pkg::result_t r;
      int unsigned      posts;
      int unsigned      data_end;
      logic [15:0]      w;
      logic [15:0]      mag;
      r = '0;
      if (first) begin
        clear_record();
        if (b != erd_pkg::SENTINEL) begin
          skipping = 1'b1;
          r.result_kind = erd_pkg::KIND_ERROR;
          due_results.push_back(r);
          return 1'b1;
        end
        skipping = 1'b0;
        byte_sum = 32'(b);
        pos = 1;
        return 1'b1;
      end
      if (skipping) return 1'b0;
      posts = (posts_cfg > erd_pkg::MAX_POSTS) ? erd_pkg::MAX_POSTS : posts_cfg;
      data_end = erd_pkg::POS_POSTS + 2 * posts;
      if (pos < data_end) begin
        byte_sum = byte_sum + 32'(b);
        if (pos == erd_pkg::POS_BLOCK || pos == erd_pkg::POS_LON ||
            pos == erd_pkg::POS_LAT) begin
          hold = b;
        end else if (pos == erd_pkg::POS_BLOCK + 1) begin
          blk = {hold, b};
        end else if (pos == erd_pkg::POS_LON + 1) begin
          lon = {hold, b};
        end else if (pos == erd_pkg::POS_LAT + 1) begin
          lat = {hold, b};
        end else if (pos >= erd_pkg::POS_POSTS) begin
          if (((pos - erd_pkg::POS_POSTS) & 1) == 0) begin
            hold = b;
          end else begin
            w = {hold, b};
            mag = {1'b0, w[14:0]};
            r.result_kind = erd_pkg::KIND_POST;
            r.elevation = w[15] ? (~mag + 16'd1) : mag;
            r.post_index = post_cnt;
            post_cnt = post_cnt + 1'b1;
            due_results.push_back(r);
          end
        end
        pos = pos + 1;
        return 1'b1;
      end
      trail = {trail[23:0], b};
      if (pos >= data_end + erd_pkg::POS_TAIL) begin
        r.result_kind = erd_pkg::KIND_SUMMARY;
        r.block_count = blk;
        r.longitude_index = lon;
        r.latitude_index = lat;
        r.stored_sum = trail;
        r.computed_sum = byte_sum;
        r.sum_matches = (trail == byte_sum);
        due_results.push_back(r);
        skipping = 1'b1;
        pos = 0;
      end else begin
        pos = pos + 1;
      end
      return 1'b1;
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(erd_pkg::result_t got);
      erd_pkg::result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result_kind mismatch, expected none actual %0h", $time,
                 got.result_kind);
        errors++;
        return;
      end
      want = due_results.pop_front();
      cmp_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
      cmp_field("elevation", 32'(want.elevation), 32'(got.elevation));
      cmp_field("post_index", 32'(want.post_index), 32'(got.post_index));
      cmp_field("block_count", 32'(want.block_count), 32'(got.block_count));
      cmp_field("longitude_index", 32'(want.longitude_index), 32'(got.longitude_index));
      cmp_field("latitude_index", 32'(want.latitude_index), 32'(got.latitude_index));
      cmp_field("stored_sum", want.stored_sum, got.stored_sum);
      cmp_field("computed_sum", want.computed_sum, got.computed_sum);
      cmp_field("sum_matches", 32'(want.sum_matches), 32'(got.sum_matches));
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [erd_pkg::CFG_W-1:0] posts_per_record;
  logic                      in_valid;
  logic                      in_ready;
  logic [7:0]                data_byte;
  logic                      record_start;
  logic                      out_valid;
  logic                      out_ready;
  logic [1:0]                result_kind;
  logic signed [15:0]        elevation;
  logic [erd_pkg::IDX_W-1:0] post_index;
  logic [15:0]               block_count;
  logic [15:0]               longitude_index;
  logic [15:0]               latitude_index;
  logic [31:0]               stored_sum;
  logic [31:0]               computed_sum;
  logic                      sum_matches;

  deframe_scoreboard board = new();
  logic [7:0]        seq_q[$];
  int                live_words = 0;
  int                sender_calm = 0;
  bit                quiet = 1'b0;
  bit                long_hold_req = 1'b0;

  elevation_record_deframer dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .posts_per_record_i (posts_per_record),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .data_byte_i        (data_byte),
    .record_start_i     (record_start),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .result_kind_o      (result_kind),
    .elevation_o        (elevation),
    .post_index_o       (post_index),
    .block_count_o      (block_count),
    .longitude_index_o  (longitude_index),
    .latitude_index_o   (latitude_index),
    .stored_sum_o       (stored_sum),
    .computed_sum_o     (computed_sum),
    .sum_matches_o      (sum_matches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("elevation_record_deframer test failed");
    $finish;
  end

  always @(posedge clk) begin
    erd_pkg::result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.result_kind = erd_pkg::kind_e'(result_kind);
      got.elevation = elevation;
      got.post_index = post_index;
      got.block_count = block_count;
      got.longitude_index = longitude_index;
      got.latitude_index = latitude_index;
      got.stored_sum = stored_sum;
      got.computed_sum = computed_sum;
      got.sum_matches = sum_matches;
      board.check_word(got);
    end
  end

  // receiver side: short random stalls, calm stretches, one long hold
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 40) == 0) calm_left = $urandom_range(20, 60);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_word(input logic [7:0] b, input logic first);
    if (sender_calm > 0) begin
      sender_calm--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end else if ($urandom_range(0, 60) == 0) begin
      sender_calm = $urandom_range(20, 60);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    record_start <= first;
    do @(posedge clk); while (!in_ready);
    if (board.note_word(b, first)) live_words++;
    @(negedge clk);
  endtask

  task automatic write_posts(input logic [erd_pkg::CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    posts_per_record <= v;
    do @(posedge clk); while (!cfg_ready);
    board.posts_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic fill_body();
    int n;
    n = erd_pkg::POS_POSTS + 2 * int'(board.posts_cfg);
    seq_q.delete();
    seq_q.push_back(erd_pkg::SENTINEL);
    for (int i = 1; i < n; i++) seq_q.push_back(pick_byte());
  endtask

  task automatic append_checksum(input bit corrupt);
    logic [31:0] s;
    s = '0;
    foreach (seq_q[i]) s = s + 32'(seq_q[i]);
    if (corrupt) s = s ^ (32'd1 << $urandom_range(0, 31));
    for (int k = 3; k >= 0; k--) seq_q.push_back(s[8*k +: 8]);
  endtask

  task automatic play_seq(input int count);
    for (int i = 0; i < count; i++) send_word(seq_q[i], i == 0);
  endtask

  initial begin
    logic [7:0]  bad;
    int unsigned kind;
    bit          open_record;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    posts_per_record = '0;
    in_valid = 1'b0;
    data_byte = '0;
    record_start = 1'b0;
    open_record = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // noise while skipping, bad sentinels, then a three post record
    write_posts(12'd3);
    send_word(8'h13, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'hAB, 1'b1);
    seq_q = '{erd_pkg::SENTINEL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h12, 8'h34,
              8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF};
    append_checksum(1'b0);
    play_seq(seq_q.size());
    send_word(erd_pkg::SENTINEL, 1'b0);
    drain();

    // no posts, wrong checksum
    write_posts(12'd0);
    fill_body();
    append_checksum(1'b1);
    play_seq(seq_q.size());
    drain();

    // shrink the post count mid record past the trailer end
    write_posts(12'd4);
    fill_body();
    play_seq(seq_q.size());
    drain();
    write_posts(12'd1);
    send_word(8'h5A, 1'b0);
    drain();

    while (live_words < 620) begin
      case ($urandom_range(0, 9))
        0: write_posts(12'd0);
        1: write_posts(erd_pkg::CFG_W'($urandom_range(7, 40)));
        default: write_posts(erd_pkg::CFG_W'($urandom_range(1, 6)));
      endcase
      if (open_record) repeat ($urandom_range(1, 6)) send_word(pick_byte(), 1'b0);
      repeat ($urandom_range(3, 8)) begin
        kind = $urandom_range(0, 19);
        if (kind == 18) begin
          do bad = pick_byte(); while (bad == erd_pkg::SENTINEL);
          send_word(bad, 1'b1);
          repeat ($urandom_range(0, 4)) send_word(pick_byte(), 1'b0);
        end else begin
          if (kind == 19) repeat ($urandom_range(1, 4)) send_word(pick_byte(), 1'b0);
          fill_body();
          append_checksum(kind == 14 || kind == 15);
          if (kind == 16 || kind == 17) play_seq($urandom_range(1, seq_q.size() - 1));
          else play_seq(seq_q.size());
        end
      end
      open_record = ($urandom_range(0, 2) == 0);
      if (open_record) begin
        fill_body();
        append_checksum(1'b0);
        play_seq($urandom_range(9, seq_q.size() - 1));
      end
      drain();
    end

    // post heavy record, with the receiver holding off at its start
    write_posts(12'd24);
    fill_body();
    append_checksum(1'b0);
    long_hold_req = 1'b1;
    play_seq(seq_q.size());
    drain();

    quiet = 1'b1;
    write_posts(12'd2);
    repeat (6) begin
      fill_body();
      append_checksum($urandom_range(0, 3) == 0);
      play_seq(seq_q.size());
    end
    drain();
    repeat (10) @(posedge clk);

    if (board.errors == 0 && board.due_results.size() == 0)
      $display("elevation_record_deframer test passed");
    else
      $display("elevation_record_deframer test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/erd_pkg.sv
rtl/core/erd_parse.sv
rtl/core/erd_out_stage.sv
rtl/core/elevation_record_deframer.sv
dv/tb_top.sv
